[design/tpd_pkg.sv]
package tpd_pkg;

  // frame lengths in bytes for the two tablet formats
  localparam logic [2:0] FIVE_LEN = 3'd5;
  localparam logic [2:0] SIX_LEN  = 3'd6;

  // format codes
  localparam logic FMT_FIVE = 1'b0;
  localparam logic FMT_SIX  = 1'b1;

  // number of bytes held for one frame
  localparam int unsigned FRAME_BYTES = 6;

  // button codes above this value set a button bit in format 0
  localparam logic [5:0] BUTTON_BASE = 6'd30;
  localparam logic [5:0] BUTTON_HIGH = 6'd32;

  // one complete frame on its way from the framer to the decoder
  typedef struct packed {
    logic                        fmt;
    logic [FRAME_BYTES-1:0][6:0] bytes;
  } frame_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/tablet_packet_decoder_unit.sv]
// Tablet packet decoder.
// Input channel: one received serial byte per request (in_rx_byte), valid/stall.
// A byte with bit 7 set starts a frame; five bytes (format 0) or six (format 1)
// complete it and produce one position request on the output channel.
// Output channel: x, y, pen status and the wrapping sample count, valid/stall.
// Config channel: cfg_tablet_format, valid/ready, always ready; write it only
// while no frame is in flight.
// Throughput: one byte per cycle while in_stall is low; a result leaves at
// most once per cycle from the decoder's output register.
// A completed frame is written into the frame queue and then decoded into
// the output register, where out_valid marks the result.
// When the receiver stalls, the output holds; completed frames pile up in a
// queue of QUEUE_DEPTH entries, and in_stall rises only once it is full.
// Reset: byte count, sample count and format return to zero, the queue empties;
// the frame bytes themselves are not cleared.
module tablet_packet_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_tablet_format,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_x_position,
  output logic [15:0] out_y_position,
  output logic [15:0] out_pen_status,
  output logic [15:0] out_sample_count
);

  tpd_pkg::q_stat_t q_stat;
  tpd_pkg::frame_t  push_frame;
  tpd_pkg::frame_t  head_frame;
  logic             push;
  logic             pop;

  // framer
  tpd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_tablet_format (cfg_tablet_format),
    .q_stat            (q_stat),
    .push              (push),
    .push_frame        (push_frame)
  );

  // frame queue
  tpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .q_stat     (q_stat)
  );

  // decoder and output register
  tpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_frame       (head_frame),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position),
    .out_pen_status   (out_pen_status),
    .out_sample_count (out_sample_count)
  );

endmodule

[design/tpd_front.sv]
module tpd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_tablet_format,
  input  tpd_pkg::q_stat_t   q_stat,
  output logic               push,
  output tpd_pkg::frame_t    push_frame
);

  logic                                 fmt_r;
  logic [2:0]                           cnt_r;
  logic [2:0]                           cnt_nxt;
  logic [tpd_pkg::FRAME_BYTES-1:0][6:0] buf_r;
  logic [tpd_pkg::FRAME_BYTES-1:0][6:0] buf_nxt;
  logic [2:0]                           len;
  logic [2:0]                           idx;
  logic                                 restart;
  logic                                 accept;

  // format register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= tpd_pkg::FMT_FIVE;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_tablet_format;
    end
  end

  // accept bytes whenever the queue has room
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // framing: a start byte or a count at the frame length restarts the frame
  assign len     = (fmt_r == tpd_pkg::FMT_SIX) ? tpd_pkg::SIX_LEN : tpd_pkg::FIVE_LEN;
  assign restart = in_rx_byte[7] || (cnt_r >= len);
  assign idx     = restart ? 3'd0 : cnt_r;
  assign cnt_nxt = idx + 3'd1;

  // frame buffer with the new byte merged in
  always_comb begin
    buf_nxt = buf_r;
    for (int i = 0; i < tpd_pkg::FRAME_BYTES; i++) begin
      if (idx == 3'(i)) begin
        buf_nxt[i] = in_rx_byte[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= buf_nxt;
    end
  end

  // hand a complete frame to the queue
  assign push             = accept && (cnt_nxt == len);
  assign push_frame.fmt   = fmt_r;
  assign push_frame.bytes = buf_nxt;

endmodule

[design/tpd_queue.sv]
module tpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpd_pkg::frame_t  push_frame,
  input  logic             pop,
  output tpd_pkg::frame_t  head_frame,
  output tpd_pkg::q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tpd_pkg::frame_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_frame   = slot_r[rd_ptr_r];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // no overflow, no underflow, count stays in range and holds without net change
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full && !pop)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty)) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue count out of range");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push == pop) |=> $stable(cnt_r)) else $error("queue count moved without net change");
`endif

endmodule

[design/tpd_back.sv]
module tpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tpd_pkg::q_stat_t q_stat,
  input  tpd_pkg::frame_t  head_frame,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_x_position,
  output logic [15:0]      out_y_position,
  output logic [15:0]      out_pen_status,
  output logic [15:0]      out_sample_count
);

  logic        out_valid_r;
  logic [15:0] x_r;
  logic [15:0] y_r;
  logic [15:0] status_r;
  logic [15:0] count_r;
  logic [15:0] x_nxt;
  logic [15:0] y_nxt;
  logic [15:0] status_nxt;
  logic [6:0]  b0;
  logic [5:0]  k;
  logic [3:0]  bit_sel;

  // take a frame when the output register is free or being emptied
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  assign b0      = head_frame.bytes[0];
  assign k       = b0[5:0];
  assign bit_sel = (k >= tpd_pkg::BUTTON_HIGH) ? k[4:1] : 4'd0;

  // decode the head frame
  always_comb begin
    if (head_frame.fmt == tpd_pkg::FMT_SIX) begin
      x_nxt      = {b0[1:0], head_frame.bytes[1], head_frame.bytes[2]};
      y_nxt      = {head_frame.bytes[3][1:0], head_frame.bytes[4], head_frame.bytes[5]};
      status_nxt = {11'd0, b0[6:2]};
    end else begin
      x_nxt      = {2'b00, head_frame.bytes[1], head_frame.bytes[2]};
      y_nxt      = {2'b00, head_frame.bytes[3], head_frame.bytes[4]};
      status_nxt = {b0[6], 15'd0};
      if (k > tpd_pkg::BUTTON_BASE) begin
        status_nxt = status_nxt | (16'd1 << bit_sel);
      end
      // out of proximity near the left edge (x under 256)
      if (x_nxt[15:8] == 8'd0) begin
        status_nxt[15] = 1'b0;
      end
    end
  end

  // output register and sample counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= 16'd0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        count_r     <= count_r + 16'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x_position   = x_r;
  assign out_y_position   = y_r;
  assign out_pen_status   = status_r;
  assign out_sample_count = count_r;

`ifndef SYNTHESIS
  // the counter moves exactly when a new request is loaded
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_sample_count == $past(out_sample_count) + 16'd1))
    else $error("sample count did not step on decode");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(out_sample_count)) else $error("sample count moved without decode");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !pop) else $error("stalled request overwritten");
`endif

endmodule

[tb/tablet_report_checker.sv]
`timescale 1ns / 1ps

module tablet_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_tablet_format,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_x_position,
  input  logic [15:0] out_y_position,
  input  logic [15:0] out_pen_status,
  input  logic [15:0] out_sample_count,
  output int          fail_count,
  output int          pending
);

  // one position report as it leaves the block
  typedef struct packed {
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic [15:0] pen_status;
    logic [15:0] sample_count;
  } pen_report_t;

  pen_report_t report_q[$];

  // shadow copy of the framer state
  logic       fmt_q;
  logic [6:0] held [0:tpd_pkg::FRAME_BYTES-1];
  logic [2:0] held_cnt;
  logic [15:0] frames_seen;
  int         reports_shown;

  // frame one byte and queue the report it completes, if any
  task automatic absorb_byte(input logic [7:0] c);
    logic [2:0]  len;
    logic [5:0]  k;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] st;
    int          btn;
    pen_report_t r;
    len = (fmt_q == tpd_pkg::FMT_SIX) ? tpd_pkg::SIX_LEN : tpd_pkg::FIVE_LEN;
    if (c[7] || held_cnt >= len) held_cnt = 3'd0;
    held[held_cnt] = c[6:0];
    held_cnt = held_cnt + 3'd1;
    if (held_cnt == len) begin
      if (fmt_q == tpd_pkg::FMT_SIX) begin
        x  = {held[0][1:0], held[1], held[2]};
        y  = {held[3][1:0], held[4], held[5]};
        st = {11'd0, held[0][6:2]};
      end else begin
        k  = held[0][5:0];
        st = held[0][6] ? 16'h8000 : 16'h0000;
        // button codes above the base set one bit, code 31 lands on bit 0
        if (k > tpd_pkg::BUTTON_BASE) begin
          btn = (k >= tpd_pkg::BUTTON_HIGH) ? int'((k - tpd_pkg::BUTTON_HIGH) >> 1) : 0;
          st[btn] = 1'b1;
        end
        x = {2'b00, held[1], held[2]};
        // no proximity near the left edge
        if (x < 16'd256) st[15] = 1'b0;
        y = {2'b00, held[3], held[4]};
      end
      frames_seen = frames_seen + 16'd1;
      r = '{x, y, st, frames_seen};
      report_q.push_back(r);
    end
  endtask

  // compare one accepted report with the oldest expected one
  task automatic check_report();
    pen_report_t want;
    pen_report_t got;
    got = '{out_x_position, out_y_position, out_pen_status, out_sample_count};
    if (report_q.size() == 0) begin
      fail_count++;
      if (reports_shown < 10) begin
        $display("unexpected report x=%h y=%h status=%h count=%h",
                 got.x_position, got.y_position, got.pen_status, got.sample_count);
        reports_shown++;
      end
    end else begin
      want = report_q.pop_front();
      if (want !== got) begin
        fail_count++;
        if (reports_shown < 10) begin
          $display({"report mismatch exp x=%h y=%h status=%h count=%h",
                    " got x=%h y=%h status=%h count=%h"},
                   want.x_position, want.y_position, want.pen_status, want.sample_count,
                   got.x_position, got.y_position, got.pen_status, got.sample_count);
          reports_shown++;
        end
      end
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_q         = tpd_pkg::FMT_FIVE;
      held_cnt      = 3'd0;
      frames_seen   = 16'd0;
      fail_count    = 0;
      reports_shown = 0;
      report_q.delete();
    end else begin
      if (out_valid && !out_stall) check_report();
      // a byte taken at the same edge as a format write still sees the old format
      if (in_valid && !in_stall) absorb_byte(in_rx_byte);
      if (cfg_valid && cfg_ready) fmt_q = cfg_tablet_format;
    end
    pending = report_q.size();
  end

endmodule

[tb/tablet_packet_decoder_unit_tb.sv]
`timescale 1ns / 1ps

module tablet_packet_decoder_unit_tb;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_tablet_format = tpd_pkg::FMT_FIVE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_x_position;
  logic [15:0] out_y_position;
  logic [15:0] out_pen_status;
  logic [15:0] out_sample_count;
  int          fail_count;
  int          pending;

  logic         fast_mode = 1'b0;
  logic         stall_enable = 1'b1;
  logic         cur_fmt = tpd_pkg::FMT_FIVE;
  int           burst_left = 0;
  int           sent_total = 0;
  int           stall_left = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0]   dir_bytes[$];

  always #5 clk = ~clk;

  tablet_packet_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tablet_format(cfg_tablet_format),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position),
    .out_pen_status   (out_pen_status),
    .out_sample_count (out_sample_count)
  );

  tablet_report_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tablet_format(cfg_tablet_format),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_position   (out_x_position),
    .out_y_position   (out_y_position),
    .out_pen_status   (out_pen_status),
    .out_sample_count (out_sample_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // receiver back-pressure in stretches of differing style
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(5, 60);
    end
    stall_left--;
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  // one byte request, with bursts and gaps unless streaming flat out
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!fast_mode && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    sent_total++;
  endtask

  // stop sending and wait until every report has come out
  task automatic drain_reports();
    @(negedge clk);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // format register write, only called once drained
  task automatic write_format(input logic v);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_tablet_format <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_fmt = v;
  endtask

  task automatic send_list();
    foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
  endtask

  // start byte, in format 0 with button codes around the threshold half the time
  task automatic send_start(input logic fmt);
    logic [31:0] r;
    r = $urandom;
    if (fmt == tpd_pkg::FMT_FIVE && r[31]) send_byte({1'b1, r[6], 6'($urandom_range(28, 63))});
    else send_byte({1'b1, r[6:0]});
  endtask

  // data byte, the second one often 0 to 2 so x can fall under 256
  task automatic send_data(input int pos);
    logic [31:0] r;
    r = $urandom;
    if (pos == 1 && r[31:30] == 2'b00) send_byte(8'($urandom_range(0, 2)));
    else send_byte({1'b0, r[6:0]});
  endtask

  task automatic send_frame(input logic fmt);
    int len;
    len = int'((fmt == tpd_pkg::FMT_SIX) ? tpd_pkg::SIX_LEN : tpd_pkg::FIVE_LEN);
    send_start(fmt);
    for (int i = 1; i < len; i++) send_data(i);
  endtask

  // mostly clean frames, some noise, cut frames and overruns
  task automatic random_burst();
    int kind;
    int len;
    int n;
    logic [31:0] r;
    kind = $urandom_range(0, 99);
    len  = int'((cur_fmt == tpd_pkg::FMT_SIX) ? tpd_pkg::SIX_LEN : tpd_pkg::FIVE_LEN);
    if (kind < 75) begin
      send_frame(cur_fmt);
    end else if (kind < 83) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        r = $urandom;
        send_byte(r[7:0]);
      end
    end else if (kind < 92) begin
      n = $urandom_range(0, len - 2);
      send_start(cur_fmt);
      for (int i = 1; i <= n; i++) send_data(i);
    end else begin
      send_frame(cur_fmt);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_data(i);
    end
  endtask

  task automatic random_phase(input int n_items);
    int start;
    start = sent_total;
    while (sent_total - start < n_items) random_burst();
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // five-byte format from reset: code 31 with maximum coordinates, a restart
    // after a full frame, a restart mid-frame with x under 256 clearing proximity
    dir_bytes = {8'hDF, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
                 8'h41, 8'h00, 8'h00, 8'h7F, 8'h7F,
                 8'h9E, 8'h10,
                 8'hFF, 8'h01, 8'h7F, 8'h00, 8'h00,
                 8'hA1, 8'h05, 8'h06};
    send_list();

    // switch to six bytes with three bytes held, they count toward the frame
    drain_reports();
    write_format(tpd_pkg::FMT_SIX);
    dir_bytes = {8'h7F, 8'h7F, 8'h7F};
    send_list();

    // back to five with six held, a plain data byte restarts the frame
    drain_reports();
    write_format(tpd_pkg::FMT_FIVE);
    dir_bytes = {8'h05, 8'h7F, 8'h00, 8'h7F, 8'h00};
    send_list();

    // random phases across both formats
    for (int p = 0; p < 6; p++) begin
      drain_reports();
      if (p < 4) write_format(p[0] ? tpd_pkg::FMT_FIVE : tpd_pkg::FMT_SIX);
      else write_format(1'($urandom_range(0, 1)));
      random_phase(175);

      // flat-out stream with the receiver never stalling
      if (p == 3) begin
        drain_reports();
        fast_mode    = 1'b1;
        stall_enable = 1'b0;
        repeat (24) send_frame(cur_fmt);
        drain_reports();
        fast_mode    = 1'b0;
        stall_enable = 1'b1;
      end
    end

    drain_reports();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS tablet_packet_decoder_unit");
    end else begin
      $display("FAIL tablet_packet_decoder_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("FAIL tablet_packet_decoder_unit");
    $finish;
  end

endmodule

[tablet_packet_decoder_unit.f]
design/tpd_pkg.sv
design/tpd_front.sv
design/tpd_queue.sv
design/tpd_back.sv
design/tablet_packet_decoder_unit.sv
tb/tablet_report_checker.sv
tb/tablet_packet_decoder_unit_tb.sv
